// ===== design/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg: shared definitions for the sample voice mixer
// Request codes, sizes, derived widths and the command/status types that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int NUM_VOICES   = 4;
  localparam int SAMPLE_DEPTH = 4096;

  // fixed field widths
  localparam int REQ_W     = 2;
  localparam int IN_ADDR_W = 12;
  localparam int POS_W     = 13;
  localparam int WORD_W    = 16;

  // derived widths
  localparam int ADDR_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int AP_W   = ADDR_W + POS_W;

  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PLAY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

  typedef struct packed {
    logic load;       // write the sample memory
    logic play;       // claim the next voice
    logic tick_init;  // load the base word, rewind the voice counter
    logic issue;      // read the word of the current voice
  } dp_cmd_t;

  typedef struct packed {
    logic last_voice; // voice counter sits on the last voice
  } dp_sts_t;

  // request address modulo the memory depth
  function automatic logic [ADDR_W-1:0] map_addr(input logic [IN_ADDR_W-1:0] a);
    logic [ADDR_W+IN_ADDR_W-1:0] t;
    t = {{ADDR_W{1'b0}}, a};
    return t[ADDR_W-1:0];
  endfunction

  // start plus position modulo the memory depth
  function automatic logic [ADDR_W-1:0] sum_addr(input logic [ADDR_W-1:0] s,
                                                  input logic [POS_W-1:0] p);
    logic [AP_W-1:0] t;
    t = AP_W'(s) + AP_W'(p);
    return t[ADDR_W-1:0];
  endfunction

endpackage

// ===== design/svm_ctrl.sv =====
// ----------------------------------------------------------------------------
// svm_ctrl: sequencer for the sample voice mixer
// Decodes accepted requests and walks a tick through the voices, one memory
// read per cycle, then presents the result for one cycle.
// ----------------------------------------------------------------------------
module svm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [svm_pkg::REQ_W-1:0] in_req_type,
  input  svm_pkg::dp_sts_t       sts,
  output svm_pkg::dp_cmd_t       cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import svm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MIX   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.play      = 1'b0;
    cmd.tick_init = 1'b0;
    cmd.issue     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load      = (in_req_type == REQ_LOAD);
          cmd.play      = (in_req_type == REQ_PLAY);
          cmd.tick_init = (in_req_type == REQ_TICK);
          if (in_req_type == REQ_TICK) begin
            state_nxt = ST_MIX;
          end
        end
      end
      ST_MIX: begin
        cmd.issue = 1'b1;
        if (sts.last_voice) begin
          state_nxt = ST_DRAIN;
        end
      end
      // last voice word is added here
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

// ===== design/svm_datapath.sv =====
// ----------------------------------------------------------------------------
// svm_datapath: sample memory, voice registers and mix accumulator
// Reads one voice word per issue, adds it in the following cycle and writes the
// voice's position and active flag back.
// ----------------------------------------------------------------------------
module svm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  svm_pkg::dp_cmd_t              cmd,
  output svm_pkg::dp_sts_t              sts,
  input  logic                          cfg_we,
  input  logic                          cfg_data,
  input  logic [svm_pkg::IN_ADDR_W-1:0] in_address,
  input  logic [svm_pkg::POS_W-1:0]     in_play_length,
  input  logic signed [svm_pkg::WORD_W-1:0] in_sample_value,
  output logic signed [svm_pkg::WORD_W-1:0] out_mixed_sample,
  output logic [svm_pkg::NUM_VOICES-1:0] out_voices_busy
);
  import svm_pkg::*;

  logic [WORD_W-1:0] mem [SAMPLE_DEPTH];
  logic [WORD_W-1:0] rdata_r;

  logic              enabled_r;
  logic [ADDR_W-1:0] start_r [NUM_VOICES];
  logic [POS_W-1:0]  pos_r   [NUM_VOICES];
  logic [POS_W-1:0]  len_r   [NUM_VOICES];
  logic [NUM_VOICES-1:0] active_r;
  logic [VIDX_W-1:0] next_r, next_nxt;

  logic [VIDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [VIDX_W-1:0] proc_idx_r;
  logic              proc_vld_r;
  logic [POS_W-1:0]  p_pos_r, p_len_r;
  logic              p_act_r;
  logic [WORD_W-1:0] acc_r;

  logic [ADDR_W-1:0] rd_addr;
  logic              take;
  logic [POS_W-1:0]  pos_adv;
  logic              finished;

  assign sts.last_voice = (rd_idx_r == LAST_VOICE);
  assign rd_addr    = sum_addr(start_r[rd_idx_r], pos_r[rd_idx_r]);
  assign rd_idx_nxt = sts.last_voice ? '0 : rd_idx_r + 1'b1;
  assign next_nxt   = (next_r == LAST_VOICE) ? '0 : next_r + 1'b1;

  // second half of a voice step, on the words latched at issue
  assign take     = p_act_r && (p_pos_r < p_len_r);
  assign pos_adv  = take ? p_pos_r + 1'b1 : p_pos_r;
  assign finished = (pos_adv >= p_len_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[map_addr(in_address)] <= in_sample_value;
    end
    if (cmd.issue) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_we) begin
      enabled_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        start_r[i] <= '0;
        pos_r[i]   <= '0;
        len_r[i]   <= '0;
      end
      active_r <= '0;
      next_r   <= '0;
    end else begin
      if (cmd.play && enabled_r) begin
        // steal the voice if it is still playing
        start_r[next_r]  <= map_addr(in_address);
        len_r[next_r]    <= in_play_length;
        pos_r[next_r]    <= '0;
        active_r[next_r] <= 1'b1;
        next_r           <= next_nxt;
      end
      if (proc_vld_r && p_act_r) begin
        if (finished) begin
          pos_r[proc_idx_r]    <= '0;
          active_r[proc_idx_r] <= 1'b0;
        end else begin
          pos_r[proc_idx_r] <= pos_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      proc_vld_r <= 1'b0;
    end else begin
      proc_vld_r <= cmd.issue;
      if (cmd.tick_init) begin
        rd_idx_r <= '0;
      end else if (cmd.issue) begin
        rd_idx_r <= rd_idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      proc_idx_r <= rd_idx_r;
      p_pos_r    <= pos_r[rd_idx_r];
      p_len_r    <= len_r[rd_idx_r];
      p_act_r    <= active_r[rd_idx_r];
    end
    if (cmd.tick_init) begin
      acc_r <= in_sample_value;
    end else if (proc_vld_r && take) begin
      acc_r <= acc_r + rdata_r;
    end
  end

  assign out_mixed_sample = signed'(acc_r);
  assign out_voices_busy  = active_r;

endmodule

// ===== design/sample_voice_mixer_core.sv =====
// ----------------------------------------------------------------------------
// sample_voice_mixer_core: four-voice one-shot PCM mixer
// Sample memory loads, round-robin voice starts and per-tick mixing.
//
//   channel  direction  handshake            payload
//   in_      input      start & !busy        req_type, address, play_length,
//                                            sample_value
//   out_     output     out_valid (1 cycle)  mixed_sample, voices_busy
//   cfg_     input      cfg_valid & ready    audio_enabled
//
// Load and start requests leave busy low.
// A tick holds busy through one sample-memory read per voice through the single
// read port, a drain state to add the last word, then out_valid for one cycle;
// the next request is taken the cycle after the strobe.
// Reset (rst_n low at a clock edge) clears all voices, next voice and the
// enable; the sample memory keeps its contents. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sample_voice_mixer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [svm_pkg::REQ_W-1:0]         in_req_type,
  input  logic [svm_pkg::IN_ADDR_W-1:0]     in_address,
  input  logic [svm_pkg::POS_W-1:0]         in_play_length,
  input  logic signed [svm_pkg::WORD_W-1:0] in_sample_value,
  output logic                              out_valid,
  output logic signed [svm_pkg::WORD_W-1:0] out_mixed_sample,
  output logic [svm_pkg::NUM_VOICES-1:0]    out_voices_busy,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_audio_enabled
);
  import svm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  svm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  svm_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_audio_enabled),
    .in_address       (in_address),
    .in_play_length   (in_play_length),
    .in_sample_value  (in_sample_value),
    .out_mixed_sample (out_mixed_sample),
    .out_voices_busy  (out_voices_busy)
  );

endmodule

// ===== design/svm_checker.sv =====
// ----------------------------------------------------------------------------
// svm_checker: port-level checks for the sample voice mixer
// Result strobe timing and busy sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module svm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [svm_pkg::REQ_W-1:0] in_req_type,
  input logic                      out_valid
);
  import svm_pkg::*;

  // reset leaves the block ready with no result pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("busy or result after reset");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_TICK |=> busy)
    else $error("tick request did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result only closes a tick in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start) && $past(in_req_type) == REQ_TICK)
    else $error("busy without a tick request");

endmodule

bind sample_voice_mixer_core svm_checker u_svm_checker (.*);

// ===== bench/tb_sample_voice_mixer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sample_voice_mixer_core: self-checking bench for the four-voice mixer
// A queue-fed driver sends load, start, tick and unused-code requests while a
// monitor predicts every accepted request and checks each mix result against
// the oldest prediction. A planning copy of the mixer state loads any sample
// word a tick is about to read, so no unwritten memory word is ever mixed.
// ----------------------------------------------------------------------------
module tb_sample_voice_mixer_core;
  import svm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam int CHK          = 0;  // state copy advanced on accepted requests
  localparam int PLAN         = 1;  // state copy advanced while building stimulus
  localparam int DRAIN_CYCLES = 2 * (NUM_VOICES + 3) + 4;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [REQ_W-1:0]     kind;
    logic [IN_ADDR_W-1:0] addr;
    logic [POS_W-1:0]     len;
    logic [WORD_W-1:0]    word;
  } mix_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]     mixed;
    logic [NUM_VOICES-1:0] voices;
  } mix_out_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [REQ_W-1:0]          in_req_type = '0;
  logic [IN_ADDR_W-1:0]      in_address = '0;
  logic [POS_W-1:0]          in_play_length = '0;
  logic signed [WORD_W-1:0]  in_sample_value = '0;
  logic                      out_valid;
  logic signed [WORD_W-1:0]  out_mixed_sample;
  logic [NUM_VOICES-1:0]     out_voices_busy;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_audio_enabled = 1'b0;

  // mixer state, one copy for checking and one for planning
  logic [WORD_W-1:0]    mix_mem    [2][SAMPLE_DEPTH];
  logic [ADDR_W-1:0]    vc_start   [2][NUM_VOICES];
  logic [POS_W-1:0]     vc_pos     [2][NUM_VOICES];
  logic [POS_W-1:0]     vc_len     [2][NUM_VOICES];
  bit                   vc_act     [2][NUM_VOICES];
  int                   nxt_voice  [2];
  bit                   mix_enabled[2];
  bit                   mem_written[SAMPLE_DEPTH];

  mix_req_t pending_reqs[$];
  mix_out_t expected_mix[$];
  mix_req_t drv_req;
  mix_req_t mon_req;
  mix_out_t mon_out;
  mix_out_t mon_want;
  bit       req_taken = 1'b0;
  int       req_queued = 0;
  int       req_accepted = 0;
  int       gap_pct = 0;
  int       stall_cycles = 0;
  int       mismatch_count = 0;

  sample_voice_mixer_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_address        (in_address),
    .in_play_length    (in_play_length),
    .in_sample_value   (in_sample_value),
    .out_valid         (out_valid),
    .out_mixed_sample  (out_mixed_sample),
    .out_voices_busy   (out_voices_busy),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_audio_enabled (cfg_audio_enabled)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one request to state copy c; return 1 when it yields a mix result.
  function automatic bit mix_step(input int c, input mix_req_t r, output mix_out_t o);
    logic [WORD_W-1:0]     acc;
    logic [NUM_VOICES-1:0] live;
    logic [ADDR_W-1:0]     a;
    o = '0;
    case (r.kind)
      REQ_LOAD: begin
        mix_mem[c][ADDR_W'(r.addr)] = r.word;
        return 1'b0;
      end
      REQ_PLAY: begin
        if (mix_enabled[c]) begin
          vc_start[c][nxt_voice[c]] = ADDR_W'(r.addr);
          vc_len[c][nxt_voice[c]]   = r.len;
          vc_pos[c][nxt_voice[c]]   = '0;
          vc_act[c][nxt_voice[c]]   = 1'b1;
          nxt_voice[c] = (nxt_voice[c] == NUM_VOICES - 1) ? 0 : nxt_voice[c] + 1;
        end
        return 1'b0;
      end
      REQ_TICK: begin
        acc  = r.word;
        live = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (vc_act[c][v]) begin
            if (vc_pos[c][v] < vc_len[c][v]) begin
              a   = ADDR_W'(vc_start[c][v] + vc_pos[c][v]);
              acc = acc + mix_mem[c][a];
              vc_pos[c][v] = vc_pos[c][v] + 1'b1;
            end
            // free the voice once it has played its whole length
            if (vc_pos[c][v] >= vc_len[c][v]) begin
              vc_pos[c][v] = '0;
              vc_act[c][v] = 1'b0;
            end else begin
              live[v] = 1'b1;
            end
          end
        end
        o.mixed  = acc;
        o.voices = live;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic mix_req_t mk_req(input logic [REQ_W-1:0] k, input int a,
                                      input int l, input int w);
    mix_req_t r;
    r.kind = k;
    r.addr = IN_ADDR_W'(a);
    r.len  = POS_W'(l);
    r.word = WORD_W'(w);
    return r;
  endfunction

  task automatic push_req(input mix_req_t r);
    mix_out_t dummy;
    void'(mix_step(PLAN, r, dummy));
    if (r.kind == REQ_LOAD) mem_written[ADDR_W'(r.addr)] = 1'b1;
    pending_reqs.push_back(r);
    req_queued++;
  endtask

  // Before a tick, load every not yet written word an active voice is about to read.
  task automatic plan_req(input mix_req_t r);
    logic [ADDR_W-1:0] a;
    if (r.kind == REQ_TICK) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (vc_act[PLAN][v] && vc_pos[PLAN][v] < vc_len[PLAN][v]) begin
          a = ADDR_W'(vc_start[PLAN][v] + vc_pos[PLAN][v]);
          if (!mem_written[a]) push_req(mk_req(REQ_LOAD, a, $urandom_range(4096), $urandom));
        end
      end
    end
    push_req(r);
  endtask

  task automatic plan_random(input int n);
    int pick;
    int a;
    int l;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        plan_req(mk_req(REQ_LOAD, $urandom_range(SAMPLE_DEPTH - 1), $urandom_range(4096),
                        $urandom));
      end else if (pick < 48) begin
        case ($urandom_range(3))
          0: a = $urandom_range(SAMPLE_DEPTH - 32, SAMPLE_DEPTH - 1);
          1: a = $urandom_range(63);
          default: a = $urandom_range(SAMPLE_DEPTH - 1);
        endcase
        pick = $urandom_range(99);
        if (pick < 60) l = $urandom_range(12);
        else if (pick < 85) l = $urandom_range(13, 200);
        else if (pick < 93) l = 4096;
        else l = $urandom_range(4096);
        plan_req(mk_req(REQ_PLAY, a, l, $urandom));
      end else if (pick < 95) begin
        plan_req(mk_req(REQ_TICK, $urandom_range(SAMPLE_DEPTH - 1), $urandom_range(4096),
                        $urandom));
      end else begin
        plan_req(mk_req(REQ_SPARE, $urandom_range(SAMPLE_DEPTH - 1), $urandom_range(4096),
                        $urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (req_accepted != req_queued || expected_mix.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input bit en);
    @(negedge clk);
    cfg_audio_enabled <= en;
    cfg_valid         <= 1'b1;
    mix_enabled[PLAN] = en;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("ERROR %0t: %s got 0x%0h, predicted 0x%0h", $realtime, what, got, want);
  endtask

  // driver: hold a request until taken, then maybe idle
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
        drv_req = pending_reqs.pop_front();
        in_req_type     <= drv_req.kind;
        in_address      <= drv_req.addr;
        in_play_length  <= drv_req.len;
        in_sample_value <= drv_req.word;
        start           <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results first, then predict the request taken at this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (out_valid) begin
        if (expected_mix.size() == 0) begin
          report_mismatch("result with no tick pending, mixed_sample", out_mixed_sample, 0);
        end else begin
          mon_want = expected_mix.pop_front();
          if (out_mixed_sample !== mon_want.mixed)
            report_mismatch("mixed_sample", out_mixed_sample, mon_want.mixed);
          if (out_voices_busy !== mon_want.voices)
            report_mismatch("voices_busy", out_voices_busy, mon_want.voices);
        end
      end
      if (start && !busy) begin
        mon_req.kind = in_req_type;
        mon_req.addr = in_address;
        mon_req.len  = in_play_length;
        mon_req.word = in_sample_value;
        if (mix_step(CHK, mon_req, mon_out)) expected_mix.push_back(mon_out);
        req_accepted++;
      end
      if (cfg_valid && cfg_ready) mix_enabled[CHK] = cfg_audio_enabled;
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("sample_voice_mixer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    for (int c = 0; c < 2; c++) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        vc_start[c][v] = '0;
        vc_pos[c][v]   = '0;
        vc_len[c][v]   = '0;
        vc_act[c][v]   = 1'b0;
      end
      nxt_voice[c]   = 0;
      mix_enabled[c] = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // playback still off: start is dropped, unused code does nothing
    gap_pct = 36;
    plan_req(mk_req(REQ_PLAY, 0, 5, 0));
    plan_req(mk_req(REQ_TICK, 0, 0, 16'h7FFF));
    plan_req(mk_req(REQ_SPARE, 12'hFFF, 4096, 16'hFFFF));
    plan_req(mk_req(REQ_TICK, 12'hFFF, 4096, 16'h8000));
    wait_drained();
    write_enable(1'b1);

    // memory wrap, zero length, full length, voice stealing, word extremes
    plan_req(mk_req(REQ_LOAD, 12'hFFF, 0, 16'h8000));
    plan_req(mk_req(REQ_LOAD, 0, 0, 16'h7FFF));
    plan_req(mk_req(REQ_LOAD, 1, 0, 16'hFFFF));
    plan_req(mk_req(REQ_LOAD, 2, 0, 16'h0001));
    plan_req(mk_req(REQ_PLAY, 12'hFFF, 3, 0));
    plan_req(mk_req(REQ_PLAY, 0, 0, 0));
    plan_req(mk_req(REQ_TICK, 0, 0, 16'h8000));
    plan_req(mk_req(REQ_PLAY, 100, 4096, 0));
    plan_req(mk_req(REQ_PLAY, 2, 1, 0));
    plan_req(mk_req(REQ_TICK, 0, 0, 16'h7FFF));
    plan_req(mk_req(REQ_PLAY, 12'hFFE, 2, 0));
    plan_req(mk_req(REQ_TICK, 0, 0, 16'h0000));
    plan_req(mk_req(REQ_TICK, 0, 0, 16'hFFFF));
    plan_req(mk_req(REQ_TICK, 0, 0, 16'h0000));
    wait_drained();

    // each random batch also pulls in the loads its ticks need
    plan_random(360);
    wait_drained();
    gap_pct = 48;
    write_enable(1'b0);
    plan_random(120);
    wait_drained();
    write_enable(1'b1);
    plan_random(180);
    wait_drained();
    gap_pct = 0;
    plan_random(240);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("sample_voice_mixer_core: match");
    end else begin
      $display("sample_voice_mixer_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/svm_pkg.sv
design/svm_ctrl.sv
design/svm_datapath.sv
design/sample_voice_mixer_core.sv
design/svm_checker.sv
bench/tb_sample_voice_mixer_core.sv
